/* design/lrgd_pkg.sv */
package lrgd_pkg;

	localparam int DEF_MAX_BATCH = 1024;
	localparam int DEF_FRAC_BITS = 16;

	localparam int DATA_W = 32;
	localparam int GSUM_W = 48;
	localparam int LSUM_W = 56;
	localparam int MUL_W  = 33;
	localparam int PROD_W = 66;
	localparam int IN_W   = 72;
	localparam int OUT_W  = 96;
	localparam int ADDR_W = 4;

	localparam logic [1:0] LK_ABS = 2'd1;
	localparam logic [1:0] LK_HUB = 2'd2;

	localparam logic [1:0] REG_LOSS_KIND = 2'd0;
	localparam logic [1:0] REG_HUBER     = 2'd1;
	localparam logic [1:0] REG_LAMBDA    = 2'd2;
	localparam logic [1:0] REG_STEP      = 2'd3;

	localparam logic [15:0] STEP_RST = 16'd655;

	// modifier bit positions
	localparam int MB_DBL_W = 0;
	localparam int MB_DBL_B = 1;
	localparam int MB_NEG_W = 2;
	localparam int MB_NEG_B = 3;
	localparam int MB_X1P5  = 4;
	localparam int MB_HALF  = 5;
	localparam int MB_SWAP  = 6;
	localparam int MB_ZERO  = 7;

	localparam logic signed [PROD_W-1:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [PROD_W-1:0] S32_MIN = -66'sd2147483648;
	localparam logic signed [PROD_W-1:0] S48_MAX = 66'sd140737488355327;
	localparam logic signed [PROD_W-1:0] S48_MIN = -66'sd140737488355328;

	typedef enum logic [20:0] {
		ST_IDLE = 21'h000001,
		ST_WX   = 21'h000002,
		ST_E    = 21'h000004,
		ST_G    = 21'h000008,
		ST_LS   = 21'h000010,
		ST_T    = 21'h000020,
		ST_L2   = 21'h000040,
		ST_DW   = 21'h000080,
		ST_DB   = 21'h000100,
		ST_MOD  = 21'h000200,
		ST_ACC  = 21'h000400,
		ST_DWS  = 21'h000800,
		ST_DWW  = 21'h001000,
		ST_DBS  = 21'h002000,
		ST_DBW  = 21'h004000,
		ST_DLS  = 21'h008000,
		ST_DLW  = 21'h010000,
		ST_UPW  = 21'h020000,
		ST_UPB  = 21'h040000,
		ST_UPD  = 21'h080000,
		ST_OUT  = 21'h100000
	} step_t;

	typedef struct packed {
		step_t step;
		logic  accept;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX)
			r = 32'sh7FFFFFFF;
		else if (v < S32_MIN)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [GSUM_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
		logic signed [GSUM_W-1:0] r;
		if (v > S48_MAX)
			r = S48_MAX[GSUM_W-1:0];
		else if (v < S48_MIN)
			r = S48_MIN[GSUM_W-1:0];
		else
			r = v[GSUM_W-1:0];
		return r;
	endfunction

endpackage

/* design/lrgd_div.sv */
module lrgd_div #(
	parameter int DIV_W = 11
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lrgd_pkg::LSUM_W-1:0]    dividend,
	input  logic [DIV_W-1:0]               divisor,
	output logic                           done,
	output logic [lrgd_pkg::LSUM_W-1:0]    quotient
);
	import lrgd_pkg::*;

	localparam int CNT_W = $clog2(LSUM_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]    rem_q;
	logic [LSUM_W-1:0]   quo_q;
	logic [DIV_W:0]      trial;
	logic [DIV_W:0]      diff;
	logic                ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[LSUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(LSUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[LSUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/lrgd_ctrl.sv */
module lrgd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  lrgd_pkg::sts_t sts,
	output lrgd_pkg::cmd_t cmd
);
	import lrgd_pkg::*;

	step_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_WX;
			ST_WX:   state_d = ST_E;
			ST_E:    state_d = ST_G;
			ST_G:    state_d = ST_LS;
			ST_LS:   state_d = ST_T;
			ST_T:    state_d = ST_L2;
			ST_L2:   state_d = ST_DW;
			ST_DW:   state_d = ST_DB;
			ST_DB:   state_d = ST_MOD;
			ST_MOD:  state_d = ST_ACC;
			ST_ACC:  state_d = sts.close ? ST_DWS : ST_IDLE;
			ST_DWS:  state_d = ST_DWW;
			ST_DWW:  if (sts.div_done) state_d = ST_DBS;
			ST_DBS:  state_d = ST_DBW;
			ST_DBW:  if (sts.div_done) state_d = ST_DLS;
			ST_DLS:  state_d = ST_DLW;
			ST_DLW:  if (sts.div_done) state_d = ST_UPW;
			ST_UPW:  state_d = ST_UPB;
			ST_UPB:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_OUT;
			ST_OUT:  if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.step   = state_q;
	assign cmd.accept = (state_q == ST_IDLE) && s_tvalid;

endmodule

/* design/lrgd_dp.sv */
module lrgd_dp #(
	parameter int MAX_BATCH = lrgd_pkg::DEF_MAX_BATCH,
	parameter int FRAC_BITS = lrgd_pkg::DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lrgd_pkg::cmd_t               cmd,
	output lrgd_pkg::sts_t               sts,
	input  logic [lrgd_pkg::IN_W-1:0]    s_tdata,
	input  logic                         s_tlast,
	input  logic [1:0]                   loss_kind,
	input  logic [30:0]                  huber_threshold,
	input  logic [15:0]                  reg_strength,
	input  logic [15:0]                  step_size,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lrgd_pkg::OUT_W-1:0]   m_tdata,
	output logic                         m_tuser
);
	import lrgd_pkg::*;

	localparam int CNT_W = $clog2(MAX_BATCH + 1);
	localparam logic signed [GSUM_W:0] CLIP = (GSUM_W+1)'(5) <<< FRAC_BITS;
	localparam logic signed [MUL_W-1:0] ONE = MUL_W'(1) <<< FRAC_BITS;

	// sample and model state
	logic signed [31:0]        x_q, y_q, w_q, b_q;
	logic [7:0]                mod_q;
	logic                      last_q;
	logic signed [GSUM_W-1:0]  wsum_q, bsum_q;
	logic [LSUM_W-1:0]         lsum_q;
	logic [CNT_W-1:0]          cnt_q, n_q, n_nxt;

	// working registers
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  p_s1;
	logic signed [31:0]        e_q;
	logic [31:0]               ae_q;
	logic signed [MUL_W-1:0]   g_q, g_d;
	logic                      hbig_q, hbig_d;
	logic [63:0]               tsum_q, lraw_q, l2_q, loss_q;
	logic [55:0]               t_q;
	logic [71:0]               l2_prod;
	logic signed [PROD_W-1:0]  gx_q, e_wide;
	logic signed [GSUM_W-1:0]  dw_q, db_q, dwm_q, dbm_q, aw_q, ab_q;
	logic signed [51:0]        mw, mb, mt;
	logic [LSUM_W-1:0]         mean_q;
	logic [64:0]               lsum_add;

	// divider
	logic                      div_start, div_done;
	logic [LSUM_W-1:0]         div_dvd, div_quo;
	logic [GSUM_W-1:0]         wmag, bmag;
	logic signed [GSUM_W:0]    q_signed, q_clip;

	// result register
	logic                      ovalid_q, osat_q;
	logic [30:0]               omean_q;
	logic signed [31:0]        ow_q, ob_q;
	logic                      out_free;

	assign n_nxt    = cnt_q + 1'b1;
	assign out_free = !ovalid_q || m_tready;

	assign sts.close    = last_q || (n_nxt == CNT_W'(MAX_BATCH));
	assign sts.div_done = div_done;
	assign sts.out_free = out_free;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			ST_WX: begin
				mul_a = MUL_W'(w_q);
				mul_b = MUL_W'(x_q);
			end
			ST_E: begin
				mul_a = MUL_W'(w_q);
				mul_b = MUL_W'(w_q);
			end
			ST_G: begin
				if (hbig_d) begin
					mul_a = $signed({2'b00, huber_threshold});
					mul_b = $signed({1'b0, ae_q - {1'b0, huber_threshold[30:1]}});
				end else begin
					mul_a = $signed({1'b0, ae_q});
					mul_b = $signed({1'b0, ae_q});
				end
			end
			ST_LS: begin
				mul_a = MUL_W'(b_q);
				mul_b = MUL_W'(b_q);
			end
			ST_T: begin
				mul_a = g_q;
				mul_b = MUL_W'(x_q);
			end
			ST_L2: begin
				mul_a = $signed({17'b0, reg_strength});
				mul_b = MUL_W'(w_q);
			end
			ST_DW: begin
				mul_a = $signed({17'b0, reg_strength});
				mul_b = MUL_W'(b_q);
			end
			ST_UPW: begin
				mul_a = $signed({17'b0, step_size});
				mul_b = MUL_W'(aw_q);
			end
			ST_UPB: begin
				mul_a = $signed({17'b0, step_size});
				mul_b = MUL_W'(ab_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_s1 <= mul_a * mul_b;
	end

	// error, gradient factor and huber region
	assign e_wide = (p_s1 >>> FRAC_BITS) + PROD_W'(b_q) - PROD_W'(y_q);

	always_comb begin
		hbig_d = (loss_kind == LK_HUB) && (ae_q > {1'b0, huber_threshold});
		if (loss_kind == LK_ABS) begin
			g_d = e_q[31] ? -ONE : ONE;
		end else if (loss_kind == LK_HUB) begin
			if (hbig_d)
				g_d = e_q[31] ? -$signed({2'b00, huber_threshold})
					: $signed({2'b00, huber_threshold});
			else
				g_d = MUL_W'(e_q);
		end else begin
			g_d = MUL_W'(e_q) <<< 1;
		end
	end

	assign l2_prod = 72'(t_q) * 72'(reg_strength);

	// modifier bits, applied in bit order
	always_comb begin
		mw = 52'(dw_q);
		mb = 52'(db_q);
		if (mod_q[MB_DBL_W]) mw = mw + mw;
		if (mod_q[MB_DBL_B]) mb = mb + mb;
		if (mod_q[MB_NEG_W]) mw = -mw;
		if (mod_q[MB_NEG_B]) mb = -mb;
		if (mod_q[MB_X1P5]) begin
			mw = mw + (mw >>> 1);
			mb = mb + (mb >>> 1);
		end
		if (mod_q[MB_HALF]) begin
			mw = mw >>> 1;
			mb = mb >>> 1;
		end
		mt = mw;
		if (mod_q[MB_SWAP]) begin
			mw = mb;
			mb = mt;
		end
		if (mod_q[MB_ZERO]) begin
			mw = '0;
			mb = '0;
		end
	end

	assign lsum_add = 65'(lsum_q) + 65'(loss_q);

	// divider operands and signed quotient
	assign wmag = wsum_q[GSUM_W-1] ? GSUM_W'(-wsum_q) : GSUM_W'(wsum_q);
	assign bmag = bsum_q[GSUM_W-1] ? GSUM_W'(-bsum_q) : GSUM_W'(bsum_q);

	always_comb begin
		case (cmd.step)
			ST_DWS:  div_dvd = LSUM_W'(wmag);
			ST_DBS:  div_dvd = LSUM_W'(bmag);
			default: div_dvd = lsum_q;
		endcase
	end

	assign div_start = (cmd.step == ST_DWS) || (cmd.step == ST_DBS) || (cmd.step == ST_DLS);

	always_comb begin
		logic neg;
		neg = (cmd.step == ST_DWW) ? wsum_q[GSUM_W-1] : bsum_q[GSUM_W-1];
		q_signed = neg ? -$signed({1'b0, div_quo[GSUM_W-1:0]})
			: $signed({1'b0, div_quo[GSUM_W-1:0]});
		if (q_signed > CLIP)
			q_clip = CLIP;
		else if (q_signed < -CLIP)
			q_clip = -CLIP;
		else
			q_clip = q_signed;
	end

	lrgd_div #(.DIV_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q    <= s_tdata[31:0];
			y_q    <= s_tdata[63:32];
			mod_q  <= s_tdata[71:64];
			last_q <= s_tlast;
		end
		case (cmd.step)
			ST_E: begin
				e_q  <= sat32(e_wide);
				ae_q <= sat32(e_wide) < 0 ? 32'(-sat32(e_wide)) : 32'(sat32(e_wide));
			end
			ST_G: begin
				tsum_q <= p_s1[63:0];
				g_q    <= g_d;
				hbig_q <= hbig_d;
			end
			ST_LS: begin
				if (loss_kind == LK_ABS)
					lraw_q <= 64'(ae_q);
				else if (loss_kind == LK_HUB && !hbig_q)
					lraw_q <= p_s1[63:0] >> (FRAC_BITS + 1);
				else
					lraw_q <= p_s1[63:0] >> FRAC_BITS;
			end
			ST_T:  t_q <= 56'((tsum_q + p_s1[63:0]) >> FRAC_BITS);
			ST_L2: begin
				l2_q <= 64'(l2_prod >> 17);
				gx_q <= p_s1 >>> FRAC_BITS;
			end
			ST_DW: begin
				loss_q <= lraw_q + l2_q;
				dw_q   <= sat48(gx_q + (p_s1 >>> 16));
			end
			ST_DB: db_q <= sat48(PROD_W'(g_q) + (p_s1 >>> 16));
			ST_MOD: begin
				dwm_q <= sat48(PROD_W'(mw));
				dbm_q <= sat48(PROD_W'(mb));
			end
			ST_ACC: n_q <= n_nxt;
			ST_DWW: if (div_done) aw_q <= GSUM_W'(q_clip);
			ST_DBW: if (div_done) ab_q <= GSUM_W'(q_clip);
			ST_DLW: if (div_done) mean_q <= div_quo;
			default: ;
		endcase
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= '0;
			b_q    <= '0;
			wsum_q <= '0;
			bsum_q <= '0;
			lsum_q <= '0;
			cnt_q  <= '0;
		end else begin
			case (cmd.step)
				ST_ACC: begin
					wsum_q <= sat48(PROD_W'(wsum_q) + PROD_W'(dwm_q));
					bsum_q <= sat48(PROD_W'(bsum_q) + PROD_W'(dbm_q));
					lsum_q <= (lsum_add > 65'({LSUM_W{1'b1}})) ? {LSUM_W{1'b1}}
						: lsum_add[LSUM_W-1:0];
					if (!sts.close) cnt_q <= n_nxt;
				end
				ST_UPB: w_q <= sat32(PROD_W'(w_q) - (p_s1 >>> 16));
				ST_UPD: b_q <= sat32(PROD_W'(b_q) - (p_s1 >>> 16));
				ST_OUT: begin
					if (out_free) begin
						wsum_q <= '0;
						bsum_q <= '0;
						lsum_q <= '0;
						cnt_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.step == ST_OUT && out_free) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step == ST_OUT && out_free) begin
			osat_q  <= mean_q > LSUM_W'(32'h7FFFFFFF);
			omean_q <= (mean_q > LSUM_W'(32'h7FFFFFFF)) ? 31'h7FFFFFFF : mean_q[30:0];
			ow_q    <= w_q;
			ob_q    <= b_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {1'b0, ob_q, ow_q, omean_q};
	assign m_tuser  = osat_q;

endmodule

/* design/linear_regression_gd_trainer.sv */
// linear regression trainer, batch gradient descent on one feature
//
// samples enter on the s_ stream: x and target y in Q16.16, a byte of
// gradient modifier bits, and tlast on the last sample of an epoch. the
// model, loss and both gradients are formed on one shared 33x33 multiplier
// stepped by a sequencer, so a new sample is taken only once the last is
// done (s_tready is high only while the sequencer waits for a sample).
// closing an epoch (tlast, or the batch reaching MAX_BATCH) adds three
// serial divisions and the weight/bias update before m_tvalid rises.
// the m_ stream carries one transaction per epoch: mean loss, new weight
// and new bias, with the loss saturation flag on tuser. the result sits in
// an output register; a stalled receiver only holds the block once the next
// epoch result is ready to be written.
// the apb port writes loss kind, huber delta, l2 lambda and step size;
// write only while the block is idle.
// reset clears weight, bias, sums and sample count and loads register
// defaults; no clearing pass is needed.
module linear_regression_gd_trainer #(
	parameter int MAX_BATCH = lrgd_pkg::DEF_MAX_BATCH,
	parameter int FRAC_BITS = lrgd_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sample_x[31:0], target_y[63:32], grad_modifier[71:64]
	input  logic [lrgd_pkg::IN_W-1:0]     s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// mean_loss[30:0], new_weight[62:31], new_bias[94:63], zero pad[95]
	output logic [lrgd_pkg::OUT_W-1:0]    m_tdata,
	// loss_saturated[0]
	output logic                          m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrgd_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import lrgd_pkg::*;

	localparam logic [30:0] HUB_RST = 31'(1) << FRAC_BITS;

	logic [1:0]  kind_q;
	logic [30:0] huber_q;
	logic [15:0] lambda_q;
	logic [15:0] step_q;
	logic        wr_en;
	cmd_t        cmd;
	sts_t        sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			huber_q  <= HUB_RST;
			lambda_q <= '0;
			step_q   <= STEP_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_LOSS_KIND: kind_q   <= pwdata[1:0];
				REG_HUBER:     huber_q  <= pwdata[30:0];
				REG_LAMBDA:    lambda_q <= pwdata[15:0];
				REG_STEP:      step_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LOSS_KIND: prdata = {30'b0, kind_q};
			REG_HUBER:     prdata = {1'b0, huber_q};
			REG_LAMBDA:    prdata = {16'b0, lambda_q};
			REG_STEP:      prdata = {16'b0, step_q};
			default:       prdata = '0;
		endcase
	end

	lrgd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lrgd_dp #(
		.MAX_BATCH (MAX_BATCH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.loss_kind       (kind_q),
		.huber_threshold (huber_q),
		.reg_strength    (lambda_q),
		.step_size       (step_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser)
	);

endmodule
